FILE: src/pwc_pkg.sv
// Package for the multichannel pulse-width capture block.
// Holds channel count, field widths, event kinds and the shared event struct.
// No dependencies.
package pwc_pkg;

   localparam int NUM_CHANNELS  = 8;
   localparam int IDX_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CH_W          = 3;
   localparam int CNT_W         = 16;
   localparam int REQ_DATA_W    = 24;
   localparam int RSP_DATA_W    = 24;
   localparam logic [CNT_W-1:0] WRAP_PERIOD_RST = 16'd20000;

   typedef enum logic {
      REQ_EDGE     = 1'b0,
      REQ_OVERFLOW = 1'b1
   } req_kind_type;

   // Decision taken for one accepted transaction.
   typedef struct packed {
      logic arm;       // first edge: latch start count
      logic done;      // second edge: measurement completes
      logic add_wrap;  // an overflow fell inside the pulse
   } evt_type;

endpackage

FILE: src/pwc_start_ram.sv
// Start-count memory: one entry per channel, one write and one read port.
// Read data registered. Depends on pwc_pkg.
module pwc_start_ram (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [pwc_pkg::IDX_W-1:0]   wr_addr,
   input  logic [pwc_pkg::CNT_W-1:0]   wr_data,
   input  logic                        rd_en,
   input  logic [pwc_pkg::IDX_W-1:0]   rd_addr,
   output logic [pwc_pkg::CNT_W-1:0]   rd_data
);

   logic [pwc_pkg::CNT_W-1:0] start_mem_ff [pwc_pkg::NUM_CHANNELS];
   logic [pwc_pkg::CNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem_ff[wr_addr] <= wr_data;
      end
   end

   // Held while not read, so a stalled entry keeps its data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= start_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/pwc_chan_flags.sv
// Per-channel measuring and wrapped flags, in flip-flops.
// Decides arm / complete / wrap for each transaction. Depends on pwc_pkg.
module pwc_chan_flags (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  pwc_pkg::req_kind_type             kind,
   input  logic                              in_range,
   input  logic [pwc_pkg::IDX_W-1:0]         idx,
   output pwc_pkg::evt_type                  evt,
   output logic [pwc_pkg::NUM_CHANNELS-1:0]  measuring,
   output logic [pwc_pkg::NUM_CHANNELS-1:0]  wrapped
);

   logic [pwc_pkg::NUM_CHANNELS-1:0] measuring_ff, measuring_in;
   logic [pwc_pkg::NUM_CHANNELS-1:0] wrapped_ff, wrapped_in;
   logic is_edge;

   assign is_edge      = accept && (kind == pwc_pkg::REQ_EDGE) && in_range;
   assign evt.arm      = is_edge && !measuring_ff[idx];
   assign evt.done     = is_edge && measuring_ff[idx];
   assign evt.add_wrap = wrapped_ff[idx];

   always_comb begin
      measuring_in = measuring_ff;
      wrapped_in   = wrapped_ff;
      if (accept && (kind == pwc_pkg::REQ_OVERFLOW)) begin
         wrapped_in = wrapped_ff | measuring_ff;
      end else if (is_edge) begin
         measuring_in[idx] = !measuring_ff[idx];
         wrapped_in[idx]   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         measuring_ff <= '0;
         wrapped_ff   <= '0;
      end else begin
         measuring_ff <= measuring_in;
         wrapped_ff   <= wrapped_in;
      end
   end

   assign measuring = measuring_ff;
   assign wrapped   = wrapped_ff;

endmodule

FILE: src/pwc_width_calc.sv
// Width stage and output register: subtracts the start count read from
// memory and holds the result until taken. Depends on pwc_pkg.
module pwc_width_calc (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic [pwc_pkg::CH_W-1:0]     load_ch,
   input  logic [pwc_pkg::CNT_W-1:0]    load_sum,
   input  logic [pwc_pkg::CNT_W-1:0]    start_cnt,
   input  logic                         out_ready,
   output logic                         can_load,
   output logic                         stage_valid,
   output logic                         out_valid,
   output logic [pwc_pkg::CH_W-1:0]     out_ch,
   output logic [pwc_pkg::CNT_W-1:0]    out_width
);

   logic                       s1_valid_ff, s1_valid_in;
   logic [pwc_pkg::CH_W-1:0]   s1_ch_ff;
   logic [pwc_pkg::CNT_W-1:0]  s1_sum_ff;
   logic                       out_valid_ff, out_valid_in;
   logic [pwc_pkg::CH_W-1:0]   out_ch_ff;
   logic [pwc_pkg::CNT_W-1:0]  out_width_ff;
   logic                       out_free, s1_move;

   assign out_free = !out_valid_ff || out_ready;
   assign s1_move  = s1_valid_ff && out_free;
   assign can_load = !s1_valid_ff || out_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (load) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_ch_ff  <= load_ch;
         s1_sum_ff <= load_sum;
      end
      if (s1_move) begin
         out_ch_ff    <= s1_ch_ff;
         out_width_ff <= s1_sum_ff - start_cnt;
      end
   end

   assign stage_valid = s1_valid_ff;
   assign out_valid   = out_valid_ff;
   assign out_ch      = out_ch_ff;
   assign out_width   = out_width_ff;

endmodule

FILE: src/multichannel_pulse_width_capture.sv
// Top level of the multichannel pulse-width capture block.
// Uses pwc_pkg, pwc_chan_flags, pwc_start_ram and pwc_width_calc.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | tuser kind, tdata channel + count
//  rsp     | out       | rsp_tvalid/tready    | tdata channel + width
//  csr     | in        | csr_valid/csr_ready  | csr_data wrap period
//
// One transaction per cycle while req_tready is high; a completing edge reaches
// rsp after the start-count memory read, then the subtract into the output register.
// Flags live in flip-flops and clear at once on reset; the start-count memory
// needs no clearing, as an entry is only read after its arming edge wrote it.
// A stalled rsp holds the width stage; req_tready drops only when both are full.
module multichannel_pulse_width_capture (
   input  logic                              clock,
   input  logic                              reset,
   // req
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pwc_pkg::REQ_DATA_W-1:0]    req_tdata,  // channel, counter_now, zero pad
   input  logic                              req_tuser,  // req_type
   // rsp
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pwc_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // out_channel, pulse_width, zero pad
   // csr
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pwc_pkg::CNT_W-1:0]         csr_data    // wrap_period
);

   localparam int FIELDS_W = pwc_pkg::CH_W + pwc_pkg::CNT_W;

   logic [pwc_pkg::CNT_W-1:0]         wrap_period_ff, wrap_period_in;
   logic                              req_accept;
   pwc_pkg::req_kind_type             req_kind;
   logic [pwc_pkg::CH_W-1:0]          req_ch;
   logic [pwc_pkg::CNT_W-1:0]         req_count;
   logic [pwc_pkg::IDX_W-1:0]         req_idx;
   logic                              req_in_range;
   pwc_pkg::evt_type                  evt;
   logic [pwc_pkg::NUM_CHANNELS-1:0]  measuring;
   logic [pwc_pkg::NUM_CHANNELS-1:0]  wrapped;
   logic [pwc_pkg::CNT_W-1:0]         extra;
   logic [pwc_pkg::CNT_W-1:0]         sum;
   logic [pwc_pkg::CNT_W-1:0]         start_cnt;
   logic                              can_load;
   logic                              stage_valid;
   logic [pwc_pkg::CH_W-1:0]          rsp_ch;
   logic [pwc_pkg::CNT_W-1:0]         rsp_width;

   // Unpack request fields, lowest bit first.
   assign req_kind     = pwc_pkg::req_kind_type'(req_tuser);
   assign req_ch       = req_tdata[pwc_pkg::CH_W-1:0];
   assign req_count    = req_tdata[FIELDS_W-1:pwc_pkg::CH_W];
   assign req_idx      = pwc_pkg::IDX_W'(req_ch);
   assign req_in_range = (32'(req_ch) < 32'(pwc_pkg::NUM_CHANNELS));

   assign req_tready = can_load;
   assign req_accept = req_tvalid && req_tready;

   // Wrap period register; writes must arrive only while idle, which the block does not enforce.
   assign csr_ready = 1'b1;
   always_comb begin
      wrap_period_in = wrap_period_ff;
      if (csr_valid && csr_ready) begin
         wrap_period_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_period_ff <= pwc_pkg::WRAP_PERIOD_RST;
      end else begin
         wrap_period_ff <= wrap_period_in;
      end
   end

   pwc_chan_flags u_flags (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .kind      (req_kind),
      .in_range  (req_in_range),
      .idx       (req_idx),
      .evt       (evt),
      .measuring (measuring),
      .wrapped   (wrapped)
   );

   // Arming writes and completion reads never hit one entry in the same
   // cycle, and a read always comes after its write.
   pwc_start_ram u_ram (
      .clock   (clock),
      .wr_en   (evt.arm),
      .wr_addr (req_idx),
      .wr_data (req_count),
      .rd_en   (evt.done),
      .rd_addr (req_idx),
      .rd_data (start_cnt)
   );

   // Only one wrap counted, so the period is added at most once.
   assign extra = evt.add_wrap ? wrap_period_ff : '0;
   assign sum   = req_count + extra;

   pwc_width_calc u_calc (
      .clock       (clock),
      .reset       (reset),
      .load        (evt.done),
      .load_ch     (req_ch),
      .load_sum    (sum),
      .start_cnt   (start_cnt),
      .out_ready   (rsp_tready),
      .can_load    (can_load),
      .stage_valid (stage_valid),
      .out_valid   (rsp_tvalid),
      .out_ch      (rsp_ch),
      .out_width   (rsp_width)
   );

   assign rsp_tdata = {{(pwc_pkg::RSP_DATA_W - FIELDS_W){1'b0}}, rsp_width, rsp_ch};

`ifndef NO_ASSERTIONS
   // A flagged wrap only ever sits on a measuring channel.
   a_wrap_needs_measuring: assert property (@(posedge clock) disable iff (reset)
      (wrapped & ~measuring) == '0)
      else $error("wrapped flag set on an idle channel");

   // An arming edge leaves its channel measuring with no wrap.
   a_arm_sets_flag: assert property (@(posedge clock) disable iff (reset)
      evt.arm |=> (measuring[$past(req_idx)] && !wrapped[$past(req_idx)]))
      else $error("arming edge did not arm the channel");

   // A completing edge fills the width stage, which then holds until it moves on.
   a_done_loads_stage: assert property (@(posedge clock) disable iff (reset)
      evt.done |=> stage_valid)
      else $error("completed measurement lost before the width stage");

   // A stalled width stage blocks new requests.
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (stage_valid && rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request accepted while width stage is blocked");
`endif

endmodule
